/* sv/tcpq_pkg.sv */
// Shared types and constants for the two-class priority queue.
package tcpq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int OCC_W       = 5;

	typedef logic signed [DATA_W-1:0] data_t;
	typedef logic [CNT_W-1:0]         cnt_t;

	localparam data_t THRESHOLD_RESET = data_t'(59);

	typedef enum logic [1:0] {
		FUNC_PLAIN = 2'd0,
		FUNC_PRIO  = 2'd1,
		FUNC_DEQ   = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RSVD  = 2'd3
	} status_t;

	typedef struct packed {
		func_t func;
		data_t value;
	} in_beat_t;

	typedef struct packed {
		data_t             removed_value;
		status_t           status;
		logic [OCC_W-1:0]  occupancy;
	} out_beat_t;

	typedef struct packed {
		logic ins;
		logic pri_hi;
		logic deq;
	} cell_ctrl_t;

endpackage

/* sv/tcpq_cell.sv */
// One queue slot: holds an entry and shifts toward head or tail.
module tcpq_cell import tcpq_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  data_t      threshold,
	input  data_t      new_value,
	input  logic       occ,
	input  data_t      left_data,
	input  data_t      right_data,
	input  logic       found_in,
	output logic       found_out,
	output data_t      data
);

	data_t data_q;
	logic  stop;

	// insert point: end of leading high run for priority, else first free slot
	assign stop      = ctrl.pri_hi ? !(occ && (data_q > threshold)) : !occ;
	assign found_out = found_in | stop;
	assign data      = data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (found_in) begin
				data_q <= left_data;
			end else if (stop) begin
				data_q <= new_value;
			end
		end else if (ctrl.deq) begin
			data_q <= right_data;
		end
	end

endmodule

/* sv/two_class_priority_queue.sv */
// Top level of the two-class priority queue.
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one operation per cycle unless the input stalls; all cells of the row update together.
// The input stalls only while a result beat is held and the output is stalled.
// Reset clears the entry count, the output valid and sets the threshold to 59.
module two_class_priority_queue import tcpq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_beat_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_beat_t out_data,
	input  logic      cfg_wen,
	input  data_t     cfg_wdata
);

	data_t      thr_q;
	cnt_t       count_q;
	cnt_t       count_next;
	logic       out_valid_q;
	out_beat_t  out_data_q;
	logic       accept;
	logic       is_ins;
	logic       full;
	logic       empty;
	cell_ctrl_t ctrl;
	status_t    status;
	data_t      cell_data [QUEUE_DEPTH];
	logic       found [QUEUE_DEPTH+1];

	assign in_stall  = out_valid_q & out_stall;
	assign accept    = in_valid & ~in_stall;
	assign full      = (count_q == cnt_t'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign is_ins    = (in_data.func == FUNC_PLAIN) || (in_data.func == FUNC_PRIO);

	assign ctrl.ins    = accept & is_ins & ~full;
	assign ctrl.pri_hi = (in_data.func == FUNC_PRIO) && (in_data.value > thr_q);
	assign ctrl.deq    = accept & (in_data.func == FUNC_DEQ) & ~empty;

	assign found[0] = 1'b0;

	genvar i;
	generate
		for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
			data_t left_d;
			data_t right_d;
			if (i == 0) begin : g_first
				assign left_d = in_data.value;
			end else begin : g_mid
				assign left_d = cell_data[i-1];
			end
			if (i == QUEUE_DEPTH - 1) begin : g_last
				assign right_d = cell_data[i];
			end else begin : g_inner
				assign right_d = cell_data[i+1];
			end
			tcpq_cell u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.threshold  (thr_q),
				.new_value  (in_data.value),
				.occ        (count_q > cnt_t'(i)),
				.left_data  (left_d),
				.right_data (right_d),
				.found_in   (found[i]),
				.found_out  (found[i+1]),
				.data       (cell_data[i])
			);
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (ctrl.ins) begin
			count_next = count_q + cnt_t'(1);
		end else if (ctrl.deq) begin
			count_next = count_q - cnt_t'(1);
		end
	end

	always_comb begin
		status = ST_DONE;
		if (is_ins && full) begin
			status = ST_FULL;
		end else if ((in_data.func == FUNC_DEQ) && empty) begin
			status = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q       <= THRESHOLD_RESET;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) begin
				thr_q <= cfg_wdata;
			end
			if (accept) begin
				count_q     <= count_next;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q.removed_value <= ctrl.deq ? cell_data[0] : '0;
			out_data_q.status        <= status;
			out_data_q.occupancy     <= OCC_W'(count_next);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* sv/tcpq_checker.sv */
// Port-level checks for the two-class priority queue, bound to the top level.
module tcpq_checker import tcpq_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input logic      out_valid,
	input logic      out_stall,
	input out_beat_t out_data
);

	a_empty_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_EMPTY) |->
		(out_data.occupancy == '0) && (out_data.removed_value == '0))
		else $error("empty dequeue beat carries data or occupancy");

	a_full_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_FULL) |->
		(out_data.occupancy == OCC_W'(QUEUE_DEPTH)) && (out_data.removed_value == '0))
		else $error("dropped insert beat has wrong occupancy or data");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> out_valid)
		else $error("accepted beat produced no result");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result beat changed");

endmodule

bind two_class_priority_queue tcpq_checker u_tcpq_checker (.*);

/* tb/tb_two_class_priority_queue.sv */
// Self-checking testbench for the two-class priority queue.
`timescale 1ns / 100ps

module tb_two_class_priority_queue;
	import tcpq_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int MAX_REPORTS    = 10;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_stall;
	in_beat_t  in_data;
	logic      out_valid;
	logic      out_stall;
	out_beat_t out_data;
	logic      cfg_wen;
	data_t     cfg_wdata;

	two_class_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// mirror of the queue contents
	data_t     mirror_entries [QUEUE_DEPTH];
	int        mirror_count;
	data_t     mirror_threshold;
	out_beat_t pending_results [$];

	bit gaps_on;
	bit stalls_on;
	int stall_left;
	int idle_cycles;
	int err_count;
	int beats_in, beats_out, full_drops, empty_deqs, prio_jumps, thr_writes;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic out_beat_t apply_queue_op(in_beat_t b);
		out_beat_t r;
		data_t     v;
		int        pos;
		r = '0;
		r.status = ST_DONE;
		v = b.value;
		case (b.func)
			FUNC_PLAIN, FUNC_PRIO: begin
				if (mirror_count >= QUEUE_DEPTH) begin
					r.status = ST_FULL;
				end else begin
					pos = mirror_count;
					if (b.func == FUNC_PRIO && v > mirror_threshold) begin
						pos = 0;
						while (pos < mirror_count && mirror_entries[pos] > mirror_threshold)
							pos++;
						if (pos < mirror_count)
							prio_jumps++;
					end
					for (int i = mirror_count; i > pos; i--)
						mirror_entries[i] = mirror_entries[i-1];
					mirror_entries[pos] = v;
					mirror_count++;
				end
			end
			FUNC_DEQ: begin
				if (mirror_count == 0) begin
					r.status = ST_EMPTY;
				end else begin
					r.removed_value = mirror_entries[0];
					for (int i = 1; i < mirror_count; i++)
						mirror_entries[i-1] = mirror_entries[i];
					mirror_count--;
				end
			end
			default: ;
		endcase
		r.occupancy = OCC_W'(mirror_count);
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		else if (r < 90)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	function automatic data_t pick_value();
		int r;
		r = $urandom_range(0, 9);
		case (r)
			0, 1, 2, 3: return data_t'(mirror_threshold + $urandom_range(0, 6) - 3);
			8: begin
				case ($urandom_range(0, 3))
					0: return data_t'(32'h8000_0000);
					1: return data_t'(32'h7fff_ffff);
					2: return data_t'(0);
					default: return data_t'(-1);
				endcase
			end
			9: return data_t'($urandom_range(0, 200)) - data_t'(100);
			default: return data_t'($urandom);
		endcase
	endfunction

	// monitor: predict on input beats, check output beats
	always @(posedge clk) begin : monitor
		out_beat_t want;
		bit        moved;
		moved = 1'b0;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				want = apply_queue_op(in_data);
				pending_results.push_back(want);
				beats_in++;
				moved = 1'b1;
				if (want.status == ST_FULL)
					full_drops++;
				if (want.status == ST_EMPTY)
					empty_deqs++;
			end
			if (out_valid && !out_stall) begin
				beats_out++;
				moved = 1'b1;
				if (pending_results.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("%0t: unexpected result beat removed=%0d status=%0d occ=%0d",
							$realtime, $signed(out_data.removed_value), out_data.status,
							out_data.occupancy);
				end else begin
					want = pending_results.pop_front();
					if (out_data.removed_value !== want.removed_value ||
						out_data.status !== want.status ||
						out_data.occupancy !== want.occupancy) begin
						err_count++;
						if (err_count <= MAX_REPORTS)
							$display("%0t: mismatch removed %0d/%0d status %0d/%0d occ %0d/%0d (exp/got)",
								$realtime, $signed(want.removed_value),
								$signed(out_data.removed_value), want.status, out_data.status,
								want.occupancy, out_data.occupancy);
					end
				end
			end
		end
		if (moved || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results outstanding",
				idle_cycles, pending_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver backpressure
	always @(negedge clk) begin
		if (!stalls_on) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if ($urandom_range(0, 99) < 65) begin
			out_stall <= 1'b0;
		end else begin
			stall_left = pick_gap();
			out_stall <= 1'b1;
		end
	end

	// called at a falling edge; returns at a falling edge with valid still high
	task automatic send_item(input func_t f, input data_t v);
		int gap;
		gap = gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		in_data.func  <= f;
		in_data.value <= v;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_threshold(input data_t t);
		wait_drain();
		cfg_wen   <= 1'b1;
		cfg_wdata <= t;
		@(posedge clk);
		mirror_threshold = t;
		thr_writes++;
		@(negedge clk);
		cfg_wen <= 1'b0;
	endtask

	task automatic test_basic_ops();
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		send_item(FUNC_DEQ, data_t'(0));
		send_item(FUNC_PRIO, data_t'(60));
		send_item(FUNC_PRIO, data_t'(59));
		send_item(FUNC_PLAIN, data_t'(100));
		send_item(FUNC_PRIO, data_t'(61));
		send_item(FUNC_PRIO, data_t'(32'h7fff_ffff));
		send_item(FUNC_PRIO, data_t'(32'h8000_0000));
		send_item(FUNC_PLAIN, data_t'(0));
		send_item(FUNC_PLAIN, data_t'(-1));
		send_item(FUNC_NOP, data_t'(32'h5a5a_a5a5));
		send_item(FUNC_PRIO, data_t'(-60));
		send_item(FUNC_PLAIN, data_t'(32'h7fff_ffff));
		send_item(FUNC_PLAIN, data_t'(32'h8000_0000));
		send_item(FUNC_NOP, data_t'(32'ha5a5_5a5a));
		for (int i = 0; i < 11; i++)
			send_item(FUNC_DEQ, data_t'(-1));
		wait_drain();
	endtask

	task automatic test_fill_and_drain();
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		while (mirror_count > 0)
			send_item(FUNC_DEQ, data_t'(0));
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_item(i[0] ? FUNC_PRIO : FUNC_PLAIN, pick_value());
		send_item(FUNC_PLAIN, data_t'(7));
		send_item(FUNC_PRIO, data_t'(32'h7fff_ffff));
		send_item(FUNC_NOP, data_t'(1));
		for (int i = 0; i <= QUEUE_DEPTH; i++)
			send_item(FUNC_DEQ, data_t'(0));
		wait_drain();
	endtask

	task automatic test_threshold_extremes();
		gaps_on   = 1'b0;
		stalls_on = 1'b1;
		write_threshold(data_t'(32'h8000_0000));
		send_item(FUNC_PLAIN, data_t'(5));
		send_item(FUNC_PRIO, data_t'(32'h8000_0000));
		send_item(FUNC_PRIO, data_t'(32'h8000_0001));
		send_item(FUNC_PRIO, data_t'(-1));
		write_threshold(data_t'(32'h7fff_ffff));
		send_item(FUNC_PRIO, data_t'(32'h7fff_ffff));
		send_item(FUNC_PRIO, data_t'(3));
		for (int i = 0; i < 6; i++)
			send_item(FUNC_DEQ, data_t'(0));
		wait_drain();
	endtask

	task automatic test_random_phase(input data_t thr, input bit gaps, input bit stalls,
		input int n_items);
		int mode, left, r;
		func_t f;
		write_threshold(thr);
		gaps_on   = gaps;
		stalls_on = stalls;
		left      = 0;
		mode      = 0;
		for (int n = 0; n < n_items; n++) begin
			if (left == 0) begin
				mode = $urandom_range(0, 2);
				left = $urandom_range(20, 60);
			end
			left--;
			r = $urandom_range(0, 99);
			case (mode)
				0: f = (r < 3) ? FUNC_NOP : (r < 43) ? FUNC_PLAIN : (r < 78) ? FUNC_PRIO : FUNC_DEQ;
				1: f = (r < 3) ? FUNC_NOP : (r < 18) ? FUNC_PLAIN : (r < 33) ? FUNC_PRIO : FUNC_DEQ;
				default:
					f = (r < 4) ? FUNC_NOP : (r < 30) ? FUNC_PLAIN : (r < 56) ? FUNC_PRIO : FUNC_DEQ;
			endcase
			send_item(f, pick_value());
			if ($urandom_range(0, 199) == 0)
				wait_drain();
		end
		wait_drain();
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		out_stall  = 1'b0;
		cfg_wen    = 1'b0;
		cfg_wdata  = '0;
		gaps_on    = 1'b0;
		stalls_on  = 1'b0;
		stall_left = 0;
		idle_cycles  = 0;
		err_count    = 0;
		mirror_count = 0;
		mirror_threshold = THRESHOLD_RESET;
		for (int i = 0; i < QUEUE_DEPTH; i++)
			mirror_entries[i] = '0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_basic_ops();
		test_fill_and_drain();
		test_threshold_extremes();
		test_random_phase(data_t'(59), 1'b0, 1'b0, 150);
		test_random_phase(data_t'(32'h8000_0000), 1'b1, 1'b1, 150);
		test_random_phase(data_t'(32'h7fff_ffff), 1'b1, 1'b0, 150);
		test_random_phase(data_t'(0), 1'b0, 1'b1, 150);
		test_random_phase(data_t'(-1), 1'b1, 1'b1, 150);
		test_random_phase(data_t'($urandom), 1'b1, 1'b1, 150);
		test_random_phase(data_t'($urandom_range(0, 200)) - data_t'(100), 1'b1, 1'b1, 150);
		test_random_phase(data_t'($urandom), 1'b0, 1'b0, 150);
		test_random_phase(data_t'(60), 1'b1, 1'b1, 150);

		wait_drain();
		repeat (4) @(negedge clk);
		$display("Covered %0d operations and %0d results over %0d threshold writes.",
			beats_in, beats_out, thr_writes);
		$display("Saw %0d full drops, %0d empty dequeues, %0d priority jumps; %0d mismatches.",
			full_drops, empty_deqs, prio_jumps, err_count);
		if (err_count == 0 && pending_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

/* sim.f */
sv/tcpq_pkg.sv
sv/tcpq_cell.sv
sv/two_class_priority_queue.sv
sv/tcpq_checker.sv
tb/tb_two_class_priority_queue.sv
